/* design/sbra_pkg.sv */
// ----------------------------------------------------------------------------
// sbra_pkg
// types and constants shared by the staging block ring allocator
// ----------------------------------------------------------------------------
package sbra_pkg;

	localparam logic [1:0] FLUSH_NONE    = 2'd0;
	localparam logic [1:0] FLUSH_PARTIAL = 2'd1;
	localparam logic [1:0] FLUSH_FULL    = 2'd2;

	localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
	localparam logic [1:0] REG_BLOCK_LIMIT = 2'd1;
	localparam logic [1:0] REG_INIT_BLOCKS = 2'd2;

	localparam logic [24:0] BLOCK_SIZE_RST = 25'd262144;
	localparam logic [9:0]  BLOCK_LIMIT_RST = 10'd512;
	localparam logic [9:0]  INIT_BLOCKS_RST = 10'd3;

	// one slot record as stored in the memory
	typedef struct packed {
		logic [8:0]  id;
		logic [31:0] used;
		logic [31:0] fill;
	} slot_t;

	// divider request and answer
	typedef struct packed {
		logic        start;
		logic [32:0] num;
		logic [12:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [12:0] rem;
	} div_rsp_t;

endpackage

/* design/sbra_rem.sv */
// ----------------------------------------------------------------------------
// sbra_rem
// bit-serial remainder of a 33-bit value by a 13-bit divisor
// ----------------------------------------------------------------------------
module sbra_rem
	import sbra_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [32:0] num_q;
	logic [13:0] rem_q;
	logic [12:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [13:0] trial;

	assign trial = {rem_q[12:0], num_q[32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[31:0], 1'b0};
			if (trial >= {1'b0, den_q}) rem_q <= trial - {1'b0, den_q};
			else rem_q <= trial;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[12:0];

endmodule

/* design/staging_block_ring_allocator.sv */
// ----------------------------------------------------------------------------
// staging_block_ring_allocator
// aligned, frame-tagged region allocation over a ring of staging blocks
// ----------------------------------------------------------------------------
// Slot records live in one memory with a registered read. Items are taken one
// at a time. A frame item moves to ST_OUT, where its result is loaded into the
// output register once that register is free. An allocate item reads the slot
// at the cursor and reuses or clears that block, or, if the slot holds the
// current frame, first tests the alignment fit with the bit-serial remainder
// unit. A second block test and a partial chunk size each run that unit again.
// Inserting a block shifts every record from the cursor to the end of the
// pool, and a flush visits every live slot. A result waiting at the output
// holds back the next result, not the next item. Writing initial_blocks or
// leaving reset rebuilds the pool, one slot per cycle over MAX_BLOCKS slots,
// during which no item is accepted.
module staging_block_ring_allocator
	import sbra_pkg::*;
#(
	parameter int MAX_BLOCKS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] request_bytes,
	input  logic [12:0] alignment,
	input  logic        allow_partial,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [24:0] grant_offset,
	output logic [31:0] grant_bytes,
	output logic [8:0]  block_id,
	output logic [1:0]  flush_kind,
	output logic        oversize,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	localparam logic [4:0] ST_BUILD   = 5'd0;
	localparam logic [4:0] ST_IDLE    = 5'd1;
	localparam logic [4:0] ST_RD0     = 5'd2;
	localparam logic [4:0] ST_DIV0    = 5'd3;
	localparam logic [4:0] ST_WAIT0   = 5'd4;
	localparam logic [4:0] ST_RD1     = 5'd5;
	localparam logic [4:0] ST_DIV1    = 5'd6;
	localparam logic [4:0] ST_WAIT1   = 5'd7;
	localparam logic [4:0] ST_DECIDE  = 5'd8;
	localparam logic [4:0] ST_SHRD    = 5'd9;
	localparam logic [4:0] ST_SHWR    = 5'd10;
	localparam logic [4:0] ST_FLRD    = 5'd11;
	localparam logic [4:0] ST_FLWR    = 5'd12;
	localparam logic [4:0] ST_CRD     = 5'd13;
	localparam logic [4:0] ST_CWR     = 5'd14;
	localparam logic [4:0] ST_OUT     = 5'd15;
	localparam logic [4:0] ST_FIT     = 5'd16;
	localparam logic [4:0] ST_SEG     = 5'd17;
	localparam logic [4:0] ST_SDIV    = 5'd18;

	slot_t mem [MAX_BLOCKS];
	slot_t rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	slot_t         wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	logic [4:0]  st_q;
	logic [24:0] bsize_q;
	logic [9:0]  blimit_q;
	logic [9:0]  binit_q;
	logic [CW-1:0] live_q;
	logic [AW-1:0] cur_q;
	logic [31:0] frame_q;
	logic [CW-1:0] idx_q;
	logic [31:0] req_q;
	logic [12:0] align_q;
	logic        seg_q;
	logic [33:0] occ_q;
	logic [34:0] off_q;
	logic [32:0] size_q;
	logic [1:0]  flush_q;
	logic        second_q;
	logic        rebuild_q;
	logic [CW-1:0] nbuild_q;
	logic [24:0] o_off_q;
	logic [31:0] o_bytes_q;
	logic [8:0]  o_id_q;
	logic [1:0]  o_fk_q;
	logic        o_ovr_q;
	logic        ovalid_q;
	logic        out_free;
	logic        out_load;
	logic        ins_wr;
	logic [8:0]  ins_id_q;
	logic        ins_pend_q;

	div_req_t dreq;
	div_rsp_t drsp;
	sbra_rem u_rem (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [CW-1:0] lim_eff;
	logic [CW-1:0] init_eff;
	logic [9:0]    lim4;
	logic          may_ins;
	logic          is_idle;
	logic [34:0]   avail;
	logic [34:0]   occ_al;
	logic [34:0]   end_v;
	logic [AW-1:0] cur_next;

	always_comb begin
		lim4 = (blimit_q < 10'd4) ? 10'd4 : blimit_q;
		if (32'(lim4) > 32'(MAX_BLOCKS)) lim_eff = MAXC;
		else lim_eff = CW'(lim4);
		if (binit_q == 10'd0) init_eff = CW'(1);
		else if (32'(binit_q) > 32'(MAX_BLOCKS)) init_eff = MAXC;
		else init_eff = CW'(binit_q);
		may_ins = live_q < lim_eff;
		is_idle = (st_q == ST_IDLE) && !rebuild_q;
		occ_al = {1'b0, occ_q} + ((drsp.rem != '0) ? 35'(align_q - drsp.rem) : 35'd0);
		avail = 35'(bsize_q) - off_q;
		end_v = off_q + 35'(size_q);
		cur_next = (32'(cur_q) + 1 >= 32'(live_q)) ? '0 : cur_q + AW'(1);
	end

	assign in_stall  = !is_idle || cfg_valid;
	assign cfg_ready = is_idle && !ovalid_q;
	assign out_valid = ovalid_q;
	assign grant_offset = o_off_q;
	assign grant_bytes  = o_bytes_q;
	assign block_id     = o_id_q;
	assign flush_kind   = o_fk_q;
	assign oversize     = o_ovr_q;

	assign out_free = !ovalid_q || !out_stall;
	assign out_load = ((st_q == ST_OUT) && out_free) || (st_q == ST_CWR);

	// memory port and divider request control
	always_comb begin
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = rd_q;
		dreq.start = 1'b0;
		dreq.num   = {1'b0, rd_q.fill};
		dreq.den   = align_q;
		unique case (st_q)
			ST_BUILD: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data.id   = (idx_q < nbuild_q) ? 9'(nbuild_q - CW'(1) - idx_q) : 9'd0;
				wr_data.used = '0;
				wr_data.fill = '0;
			end
			ST_RD0, ST_RD1: rd_addr = cur_q;
			ST_DIV0, ST_DIV1: dreq.start = (rd_q.used == frame_q);
			ST_SDIV: begin
				dreq.start = 1'b1;
				dreq.num   = occ_q[32:0];
			end
			ST_SHRD: rd_addr = AW'(idx_q - CW'(1));
			ST_SHWR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_q;
			end
			ST_FLRD: rd_addr = idx_q[AW-1:0];
			ST_FLWR: begin
				wr_addr = idx_q[AW-1:0];
				wr_data.used = '0;
				wr_data.fill = '0;
				wr_en = !(flush_q == FLUSH_PARTIAL && rd_q.used == frame_q);
			end
			ST_CRD: rd_addr = cur_q;
			ST_CWR: begin
				wr_en = 1'b1;
				// a freshly inserted block takes its id from the live count
				if (ins_pend_q) wr_data.id = ins_id_q;
				wr_data.used = frame_q;
				wr_data.fill = (end_v > 35'hFFFFFFFF) ? 32'hFFFFFFFF : end_v[31:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_BUILD;
			bsize_q  <= BLOCK_SIZE_RST;
			blimit_q <= BLOCK_LIMIT_RST;
			binit_q  <= INIT_BLOCKS_RST;
			live_q   <= CW'(INIT_BLOCKS_RST);
			nbuild_q <= CW'(INIT_BLOCKS_RST);
			cur_q    <= '0;
			frame_q  <= '0;
			idx_q    <= '0;
			rebuild_q <= 1'b0;
			flush_q  <= FLUSH_NONE;
			second_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_BUILD: begin
					if (32'(idx_q) == MAX_BLOCKS - 1) begin
						idx_q <= '0;
						st_q  <= ST_IDLE;
					end else idx_q <= idx_q + CW'(1);
				end
				ST_IDLE: begin
					if (rebuild_q) begin
						rebuild_q <= 1'b0;
						nbuild_q  <= init_eff;
						live_q    <= init_eff;
						cur_q     <= '0;
						idx_q     <= '0;
						st_q      <= ST_BUILD;
					end else if (cfg_valid && cfg_ready) begin
						unique case (cfg_index)
							REG_BLOCK_SIZE: bsize_q <= cfg_data[24:0];
							REG_BLOCK_LIMIT: blimit_q <= cfg_data[9:0];
							REG_INIT_BLOCKS: begin
								binit_q   <= cfg_data[9:0];
								rebuild_q <= 1'b1;
							end
							default: ;
						endcase
					end else if (in_valid && !in_stall) begin
						req_q   <= request_bytes;
						align_q <= (alignment == '0) ? 13'd1 : alignment;
						seg_q   <= allow_partial;
						flush_q <= FLUSH_NONE;
						second_q <= 1'b0;
						if (req_type) begin
							frame_q <= frame_q + 32'd1;
							st_q    <= ST_OUT;
						end else begin
							if (32'(cur_q) >= 32'(live_q)) cur_q <= '0;
							st_q <= ST_RD0;
						end
					end
				end
				ST_OUT: if (out_free) st_q <= ST_IDLE;
				ST_RD0: st_q <= ST_DIV0;
				ST_DIV0: begin
					occ_q <= {2'b0, rd_q.fill};
					if (rd_q.used == frame_q) st_q <= ST_WAIT0;
					else begin
						off_q  <= '0;
						size_q <= {1'b0, req_q};
						st_q   <= ST_DECIDE;
					end
				end
				ST_WAIT0, ST_WAIT1: begin
					if (drsp.done) begin
						off_q <= occ_al;
						st_q  <= ST_FIT;
					end
				end
				ST_FIT: begin
					size_q <= {1'b0, req_q};
					if ({3'b0, req_q} < avail && !avail[34]) st_q <= ST_CRD;
					else if (seg_q && !avail[34] && avail >= 35'(align_q)) begin
						// divisor unit reused for the chunk size
						occ_q <= avail[33:0];
						st_q  <= ST_SDIV;
					end else begin
						off_q <= '0;
						if (!second_q) begin
							second_q <= 1'b1;
							cur_q    <= cur_next;
							st_q     <= ST_RD1;
						end else if (may_ins) begin
							idx_q <= live_q;
							st_q  <= ST_SHRD;
						end else begin
							flush_q <= FLUSH_FULL;
							idx_q   <= '0;
							st_q    <= ST_FLRD;
						end
					end
				end
				ST_SDIV: st_q <= ST_SEG;
				ST_SEG: begin
					// chunk size: avail minus avail mod align
					if (drsp.done) begin
						size_q <= 33'(occ_q - 34'(drsp.rem));
						st_q   <= ST_CRD;
					end
				end
				ST_RD1: st_q <= ST_DIV1;
				ST_DIV1: begin
					occ_q <= {2'b0, rd_q.fill};
					if (rd_q.used == frame_q) st_q <= ST_WAIT1;
					else begin
						off_q  <= '0;
						size_q <= {1'b0, req_q};
						st_q   <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					// rd_q still holds the cursor slot
					if (frame_q - rd_q.used >= 32'(live_q)) st_q <= ST_CRD;
					else if (may_ins) begin
						idx_q <= live_q;
						st_q  <= ST_SHRD;
					end else begin
						flush_q <= FLUSH_PARTIAL;
						idx_q   <= '0;
						st_q    <= ST_FLRD;
					end
				end
				ST_SHRD: begin
					if (idx_q == CW'(cur_q) || live_q >= MAXC) begin
						st_q <= ST_CRD;
						if (live_q < MAXC) live_q <= live_q + CW'(1);
					end else st_q <= ST_SHWR;
				end
				ST_SHWR: begin
					idx_q <= idx_q - CW'(1);
					st_q  <= ST_SHRD;
				end
				ST_FLRD: st_q <= ST_FLWR;
				ST_FLWR: begin
					if (idx_q + CW'(1) >= live_q) st_q <= ST_CRD;
					else begin
						idx_q <= idx_q + CW'(1);
						st_q  <= ST_FLRD;
					end
				end
				// wait here so the output register is free at the commit
				ST_CRD: if (out_free) st_q <= ST_CWR;
				ST_CWR: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q  <= 1'b0;
			o_off_q   <= '0;
			o_bytes_q <= '0;
			o_id_q    <= '0;
			o_fk_q    <= FLUSH_NONE;
			o_ovr_q   <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
			if (st_q == ST_OUT) begin
				o_off_q   <= '0;
				o_bytes_q <= '0;
				o_id_q    <= '0;
				o_fk_q    <= FLUSH_NONE;
				o_ovr_q   <= 1'b0;
			end else begin
				o_off_q   <= off_q[24:0];
				o_bytes_q <= size_q[31:0];
				o_id_q    <= ins_pend_q ? ins_id_q : rd_q.id;
				o_fk_q    <= flush_q;
				o_ovr_q   <= end_v > 35'(bsize_q);
			end
		end else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
	end

	// inserted block: its record at the cursor is written by the commit
	assign ins_wr = (st_q == ST_SHRD) && (idx_q == CW'(cur_q)) && (live_q < MAXC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ins_pend_q <= 1'b0;
		else if (ins_wr) ins_pend_q <= 1'b1;
		else if (st_q == ST_CWR) ins_pend_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (ins_wr) ins_id_q <= 9'(live_q);
	end

endmodule
